// ----- src/pfra_pkg.sv -----
// ----------------------------------------------------------------------------
// pfra_pkg
// Shared types and constants for the page frame refcount allocator.
// ----------------------------------------------------------------------------
package pfra_pkg;

  localparam int DEF_NUM_PAGES = 1024;
  localparam int DEF_PAGE_BITS = 12;

  localparam int ADDR_W = 32;
  localparam int CNT_W  = 8;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  localparam logic [CNT_W-1:0]  CNT_FREE      = 8'h00;
  localparam logic [CNT_W-1:0]  CNT_ONE       = 8'h01;
  localparam logic [CNT_W-1:0]  CNT_MAX_USERS = 8'hfe;
  localparam logic [CNT_W-1:0]  CNT_RESERVED  = 8'hff;
  localparam logic [ADDR_W-1:0] ADDR_FAIL     = 32'hffff_ffff;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_OBTAIN = 3'd1,
    OP_FREE   = 3'd2,
    OP_QUERY  = 3'd3,
    OP_AVAIL  = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NOPAGE  = 2'd1,
    ST_REFUSED = 2'd2
  } st_e;

  // controller -> datapath
  typedef struct packed {
    logic clr;     // write reserved into the clear pointer entry, advance
    logic accept;  // capture the incoming transaction, issue first read if needed
    logic exec;    // evaluate read data, advance scan if needed
    logic commit;  // load result register, write back the count
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic done;
  } sts_t;

endpackage

// ----- src/pfra_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfra_ctrl
// Sequencer: clearing pass, accept, evaluate/scan, result hand-off.
// ----------------------------------------------------------------------------
module pfra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  input  pfra_pkg::sts_t sts_i,
  output pfra_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  always_comb begin
    cmd_o        = '0;
    cmd_o.clr    = (state_q == S_CLEAR);
    cmd_o.accept = (state_q == S_IDLE) && s_valid_i;
    cmd_o.exec   = (state_q == S_EXEC);
    cmd_o.commit = cmd_o.exec && sts_i.done && (!m_valid_q || m_ready_i);

    state_d   = state_q;
    m_valid_d = m_valid_q;
    if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_o.commit) begin
          state_d   = S_IDLE;
          m_valid_d = 1'b1;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

endmodule

// ----- src/pfra_dpath.sv -----
// ----------------------------------------------------------------------------
// pfra_dpath
// Count memory, free-search hint, operation evaluation and result register.
// ----------------------------------------------------------------------------
module pfra_dpath #(
  parameter int NUM_PAGES = pfra_pkg::DEF_NUM_PAGES,
  parameter int PAGE_BITS = pfra_pkg::DEF_PAGE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pfra_pkg::cmd_t                  cmd_i,
  output pfra_pkg::sts_t                  sts_o,
  input  logic [pfra_pkg::OP_W-1:0]       opcode_i,
  input  logic [pfra_pkg::ADDR_W-1:0]     page_address_i,
  input  logic                            high_memory_i,
  output logic [pfra_pkg::ADDR_W-1:0]     result_address_o,
  output logic [pfra_pkg::CNT_W-1:0]      user_count_o,
  output logic [pfra_pkg::ST_W-1:0]       status_o
);

  localparam int IdxW  = $clog2(NUM_PAGES);
  localparam int HintW = $clog2(NUM_PAGES + 1);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(NUM_PAGES - 1);
  localparam logic [HintW-1:0] HintNone = HintW'(NUM_PAGES);

  logic [pfra_pkg::CNT_W-1:0] mem_q [NUM_PAGES];
  logic [pfra_pkg::CNT_W-1:0] rd_data_q;

  // hint: every page below it is known to be in use
  logic [HintW-1:0] hint_q, hint_d;
  logic [IdxW-1:0]  clr_q;
  logic [IdxW-1:0]  scan_q;
  pfra_pkg::op_e    op_q;
  logic [pfra_pkg::ADDR_W-1:0] addr_q;
  logic             imm_q;

  // decode of the incoming transaction
  pfra_pkg::op_e               in_op;
  logic [pfra_pkg::ADDR_W-1:0] in_idx_full;
  logic                        in_alloc, in_range, in_bad_op, in_imm;
  logic [IdxW-1:0]             start_idx;

  // evaluation
  logic                        wr_en, adv;
  logic [pfra_pkg::CNT_W-1:0]  wr_val;
  logic [pfra_pkg::ADDR_W-1:0] out_addr_d;
  logic [pfra_pkg::CNT_W-1:0]  out_cnt_d;
  pfra_pkg::st_e               out_st_d;
  logic [HintW-1:0]            hint_min;
  logic [IdxW-1:0]             scan_nxt;

  // memory ports
  logic                        rd_en, we;
  logic [IdxW-1:0]             rd_addr, wr_addr;
  logic [pfra_pkg::CNT_W-1:0]  wr_data;

  always_comb begin
    in_op       = pfra_pkg::op_e'(opcode_i);
    in_alloc    = (in_op == pfra_pkg::OP_ALLOC);
    in_idx_full = page_address_i >> PAGE_BITS;
    in_range    = (in_idx_full < pfra_pkg::ADDR_W'(NUM_PAGES));
    in_bad_op   = (opcode_i > pfra_pkg::OP_AVAIL);
    in_imm      = in_alloc ? (high_memory_i || (hint_q == HintNone))
                           : (in_bad_op || !in_range);
    start_idx   = in_alloc ? hint_q[IdxW-1:0] : in_idx_full[IdxW-1:0];
  end

  assign scan_nxt = scan_q + IdxW'(1);
  assign hint_min = (HintW'(scan_q) < hint_q) ? HintW'(scan_q) : hint_q;

  always_comb begin
    sts_o.clr_last = (clr_q == LastIdx);
    sts_o.done = 1'b1;
    adv        = 1'b0;
    wr_en      = 1'b0;
    wr_val     = rd_data_q;
    hint_d     = hint_q;
    out_addr_d = addr_q;
    out_cnt_d  = pfra_pkg::CNT_FREE;
    out_st_d   = pfra_pkg::ST_REFUSED;
    if (imm_q) begin
      if (op_q == pfra_pkg::OP_ALLOC) begin
        out_addr_d = pfra_pkg::ADDR_FAIL;
        out_st_d   = pfra_pkg::ST_NOPAGE;
      end
    end else begin
      case (op_q)
        pfra_pkg::OP_ALLOC: begin
          if (rd_data_q == pfra_pkg::CNT_FREE) begin
            out_addr_d = pfra_pkg::ADDR_W'(pfra_pkg::ADDR_W'(scan_q) << PAGE_BITS);
            out_cnt_d  = pfra_pkg::CNT_ONE;
            out_st_d   = pfra_pkg::ST_DONE;
            wr_en      = 1'b1;
            wr_val     = pfra_pkg::CNT_ONE;
            hint_d     = HintW'(scan_q) + HintW'(1);
          end else if (scan_q == LastIdx) begin
            out_addr_d = pfra_pkg::ADDR_FAIL;
            out_st_d   = pfra_pkg::ST_NOPAGE;
            hint_d     = HintNone;
          end else begin
            sts_o.done = 1'b0;
            adv        = 1'b1;
          end
        end
        pfra_pkg::OP_OBTAIN: begin
          out_cnt_d = rd_data_q;
          if (rd_data_q < pfra_pkg::CNT_MAX_USERS) begin
            wr_en     = 1'b1;
            wr_val    = rd_data_q + pfra_pkg::CNT_W'(1);
            out_cnt_d = wr_val;
            out_st_d  = pfra_pkg::ST_DONE;
          end
        end
        pfra_pkg::OP_FREE: begin
          out_cnt_d = rd_data_q;
          if (rd_data_q != pfra_pkg::CNT_RESERVED && rd_data_q != pfra_pkg::CNT_FREE) begin
            wr_en     = 1'b1;
            wr_val    = rd_data_q - pfra_pkg::CNT_W'(1);
            out_cnt_d = wr_val;
            out_st_d  = pfra_pkg::ST_DONE;
            if (wr_val == pfra_pkg::CNT_FREE) begin
              hint_d = hint_min;
            end
          end
        end
        pfra_pkg::OP_QUERY: begin
          out_cnt_d = rd_data_q;
          out_st_d  = pfra_pkg::ST_DONE;
        end
        pfra_pkg::OP_AVAIL: begin
          out_cnt_d = rd_data_q;
          if (rd_data_q == pfra_pkg::CNT_RESERVED) begin
            wr_en     = 1'b1;
            wr_val    = pfra_pkg::CNT_FREE;
            out_cnt_d = pfra_pkg::CNT_FREE;
            out_st_d  = pfra_pkg::ST_DONE;
            hint_d    = hint_min;
          end
        end
        default: ;
      endcase
    end
  end

  assign rd_en   = (cmd_i.accept && !in_imm) || (cmd_i.exec && adv);
  assign rd_addr = cmd_i.accept ? start_idx : scan_nxt;
  assign we      = cmd_i.clr || (cmd_i.commit && wr_en);
  assign wr_addr = cmd_i.clr ? clr_q : scan_q;
  assign wr_data = cmd_i.clr ? pfra_pkg::CNT_RESERVED : wr_val;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hint_q <= HintNone;
      clr_q  <= '0;
    end else begin
      if (cmd_i.clr) begin
        clr_q <= clr_q + IdxW'(1);
      end
      if (cmd_i.commit) begin
        hint_q <= hint_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= in_op;
      addr_q <= page_address_i;
      imm_q  <= in_imm;
      scan_q <= start_idx;
    end else if (cmd_i.exec && adv) begin
      scan_q <= scan_nxt;
    end
    if (cmd_i.commit) begin
      result_address_o <= out_addr_d;
      user_count_o     <= out_cnt_d;
      status_o         <= out_st_d;
    end
  end

endmodule

// ----- src/page_frame_refcount_allocator.sv -----
// ----------------------------------------------------------------------------
// page_frame_refcount_allocator
// Physical page allocator with an 8-bit user count per page.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave transaction is one operation: allocate, obtain, free, query
//   or make-available. Every operation returns exactly one master
//   transaction with the page address, the count after the operation and a
//   status (done, no free page, refused).
//   Timing: a valid, in-range non-allocate operation issues its count read
//   at the accepting edge, then evaluates and writes back the count once
//   the result register is free; the result is registered. Allocate also
//   runs a first-fit scan past in-use pages; the scan reads one count per
//   cycle from the count memory, starting at a hint that tracks the lowest
//   page that may be free. High-memory or known-full allocates skip the
//   scan. One operation is in flight at a time: the next one is accepted
//   only after the last one has loaded its result register.
//   Reset: every count starts as reserved. After reset a clearing pass
//   writes every entry of the count memory, with s_axis_tready low.
//   Stall: a held result stays on the master side; the next operation is
//   still accepted and evaluated, and waits for the result register.
// ----------------------------------------------------------------------------
module page_frame_refcount_allocator #(
  parameter int NUM_PAGES = pfra_pkg::DEF_NUM_PAGES,
  parameter int PAGE_BITS = pfra_pkg::DEF_PAGE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: one operation per transaction
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] page_address
  input  logic [3:0]  s_axis_tuser,   // [2:0] opcode, [3] high_memory
  // master side: one result per transaction
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] result_address, [39:32] user_count
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  pfra_pkg::cmd_t cmd;
  pfra_pkg::sts_t sts;

  logic [pfra_pkg::ADDR_W-1:0] result_address;
  logic [pfra_pkg::CNT_W-1:0]  user_count;
  logic [pfra_pkg::ST_W-1:0]   status;

  // sequencing: clearing pass, accept, scan/evaluate, hand-off
  pfra_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // count memory, free-page hint and result register
  pfra_dpath #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (s_axis_tuser[2:0]),
    .page_address_i   (s_axis_tdata),
    .high_memory_i    (s_axis_tuser[3]),
    .result_address_o (result_address),
    .user_count_o     (user_count),
    .status_o         (status)
  );

  // pack the result transaction
  assign m_axis_tdata = {user_count, result_address};
  assign m_axis_tuser = status;

endmodule

// ----- src/pfra_chk.sv -----
// ----------------------------------------------------------------------------
// pfra_chk
// Port-level checks for the page frame refcount allocator.
// ----------------------------------------------------------------------------
module pfra_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [3:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed or dropped");

  // nothing accepted or presented just after reset is sampled active
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !s_axis_tready && !m_axis_tvalid)
    else $error("handshake active during reset");

  // status code stays within its defined set
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("undefined status code");

  // a failed allocate reports all-ones address and zero count
  a_nopage_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == pfra_pkg::ST_NOPAGE) |->
      (m_axis_tdata[31:0] == pfra_pkg::ADDR_FAIL) && (m_axis_tdata[39:32] == 8'h00))
    else $error("failed allocate with bad fields");

  // one operation in flight: drop ready right after an accepted transaction
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second operation accepted while one is in flight");

endmodule

bind page_frame_refcount_allocator pfra_chk u_pfra_chk (.*);
